// File: src/frame_receive_and_reply_core_assert.svh
// Assertion macros for the frame receive and reply core.
`ifndef FRAME_RECEIVE_AND_REPLY_CORE_ASSERT_SVH
`define FRAME_RECEIVE_AND_REPLY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property sampled on the rising edge, off during reset.
`define FRR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent implies the consequent on the next edge.
`define FRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define FRR_ASSERT(label, clk, rstn, prop, msg)
`define FRR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: src/frr_pkg.sv
// Shared constants and types of the frame receive and reply core.
`default_nettype none

package frr_pkg;

  localparam int unsigned HDR_LEN     = 8;
  localparam int unsigned MAX_PAYLOAD = 32;

  localparam int unsigned HDR_AW = $clog2(HDR_LEN);
  localparam int unsigned PAY_AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned RIDX_W = $clog2(HDR_LEN + MAX_PAYLOAD + 1);

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] RST_CFG_CMD     = 8'h01;
  localparam logic [7:0] RST_OK_RSP      = 8'h01;
  localparam logic [7:0] RST_UNKNOWN_RSP = 8'hEE;

  localparam logic [1:0] REG_CFG_CMD     = 2'd0;
  localparam logic [1:0] REG_OK_RSP      = 2'd1;
  localparam logic [1:0] REG_UNKNOWN_RSP = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SYNC = 2'd1;
  localparam logic [1:0] STAT_BAD_SUM  = 2'd2;
  localparam logic [1:0] STAT_TOO_LONG = 2'd3;

  typedef struct packed {
    logic       hdr_wr;
    logic       hdr_done;
    logic       pay_wr;
    logic       pay_done;
    logic       restart;
    logic       err;
    logic [1:0] err_code;
    logic       reply_start;
    logic       reply_step;
  } frr_cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic sync_ok;
    logic len_zero;
    logic pay_last;
    logic too_long;
    logic sum_ok;
    logic reply_end;
    logic out_hold;
  } frr_stat_t;

endpackage

`default_nettype wire

// File: src/frr_datapath.sv
// Datapath: header and payload stores, counters, checksum, config and output register.
`default_nettype none
`include "frame_receive_and_reply_core_assert.svh"

module frr_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             out_stall_i,
  input  wire frr_pkg::frr_cmd_t  cmd_i,
  output frr_pkg::frr_stat_t      stat_o,
  output logic                  out_valid_o,
  output logic [7:0]            tx_byte_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);
  import frr_pkg::*;

  logic [7:0] cfg_cmd_q, ok_rsp_q, unk_rsp_q;
  logic [7:0] hdr_q [HDR_LEN];
  logic [7:0] pay_q [MAX_PAYLOAD];
  logic [31:0] count_q, len_q;
  logic [7:0] sum_q;
  logic [RIDX_W-1:0] ridx_q;
  logic [RIDX_W-1:0] pidx;
  logic [31:0] len_new;
  logic [7:0] rsp, reply_byte;
  logic out_valid_q, last_q;
  logic [7:0] tx_q;
  logic [1:0] status_q;
  logic out_take, out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cmd_q <= RST_CFG_CMD;
      ok_rsp_q  <= RST_OK_RSP;
      unk_rsp_q <= RST_UNKNOWN_RSP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CFG_CMD:     cfg_cmd_q <= cfg_data_i;
        REG_OK_RSP:      ok_rsp_q  <= cfg_data_i;
        REG_UNKNOWN_RSP: unk_rsp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_new = {rx_byte_i, hdr_q[6], hdr_q[5], hdr_q[4]};
  assign rsp     = (hdr_q[1] == cfg_cmd_q) ? ok_rsp_q : unk_rsp_q;
  assign pidx    = ridx_q - RIDX_W'(HDR_LEN);

  always_comb begin
    if (ridx_q == RIDX_W'(3)) begin
      reply_byte = rsp;
    end else if (ridx_q < RIDX_W'(HDR_LEN)) begin
      reply_byte = hdr_q[ridx_q[HDR_AW-1:0]];
    end else if (stat_o.reply_end) begin
      reply_byte = sum_q;
    end else begin
      reply_byte = pay_q[pidx[PAY_AW-1:0]];
    end
  end

  assign stat_o.hdr_last  = (count_q[HDR_AW-1:0] == HDR_AW'(HDR_LEN - 1));
  assign stat_o.sync_ok   = (hdr_q[0] == SYNC_BYTE);
  assign stat_o.len_zero  = (len_new == 32'd0);
  assign stat_o.pay_last  = ((count_q + 32'd1) == len_q);
  assign stat_o.too_long  = (len_q > 32'(MAX_PAYLOAD));
  assign stat_o.sum_ok    = (sum_q == rx_byte_i);
  assign stat_o.reply_end = (ridx_q == (RIDX_W'(HDR_LEN) + len_q[RIDX_W-1:0]));
  assign stat_o.out_hold  = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr) begin
      hdr_q[count_q[HDR_AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.pay_wr && (count_q < 32'(MAX_PAYLOAD))) begin
      pay_q[count_q[PAY_AW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      ridx_q  <= '0;
    end else begin
      if (cmd_i.hdr_wr || cmd_i.pay_wr) begin
        count_q <= count_q + 32'd1;
        sum_q   <= sum_q + rx_byte_i;
      end
      if (cmd_i.hdr_done) begin
        count_q <= '0;
        len_q   <= len_new;
      end
      if (cmd_i.pay_done) begin
        count_q <= '0;
      end
      if (cmd_i.reply_start) begin
        sum_q  <= '0;
        ridx_q <= '0;
      end
      if (cmd_i.reply_step) begin
        sum_q  <= sum_q + reply_byte;
        ridx_q <= ridx_q + RIDX_W'(1);
      end
      if (cmd_i.restart) begin
        count_q <= '0;
        sum_q   <= '0;
      end
    end
  end

  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = cmd_i.err || cmd_i.reply_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err) begin
      tx_q     <= 8'h00;
      status_q <= cmd_i.err_code;
      last_q   <= 1'b1;
    end else if (cmd_i.reply_step) begin
      tx_q     <= reply_byte;
      status_q <= STAT_OK;
      last_q   <= stat_o.reply_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  `FRR_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, cmd_i.restart, (sum_q == 8'd0) && (count_q == 32'd0), "restart left count or sum set")

endmodule

`default_nettype wire

// File: src/frr_ctrl.sv
// Controller: frame phase state machine and handshake control.
`default_nettype none
`include "frame_receive_and_reply_core_assert.svh"

module frr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire frr_pkg::frr_stat_t stat_i,
  output frr_pkg::frr_cmd_t       cmd_o
);
  import frr_pkg::*;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_CHECK,
    ST_REPLY
  } state_e;

  state_e state_q, state_d;
  logic   may_emit, in_fire;

  assign may_emit   = (state_q == ST_CHECK) || ((state_q == ST_HEADER) && stat_i.hdr_last);
  assign in_stall_o = (state_q == ST_REPLY) || (may_emit && stat_i.out_hold);
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_HEADER: begin
        if (in_fire) begin
          cmd_o.hdr_wr = 1'b1;
          if (stat_i.hdr_last) begin
            if (!stat_i.sync_ok) begin
              cmd_o.err      = 1'b1;
              cmd_o.err_code = STAT_BAD_SYNC;
              cmd_o.restart  = 1'b1;
            end else begin
              cmd_o.hdr_done = 1'b1;
              state_d = stat_i.len_zero ? ST_CHECK : ST_PAYLOAD;
            end
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          cmd_o.pay_wr = 1'b1;
          if (stat_i.pay_last) begin
            cmd_o.pay_done = 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (in_fire) begin
          if (stat_i.too_long) begin
            cmd_o.err      = 1'b1;
            cmd_o.err_code = STAT_TOO_LONG;
            cmd_o.restart  = 1'b1;
            state_d = ST_HEADER;
          end else if (!stat_i.sum_ok) begin
            cmd_o.err      = 1'b1;
            cmd_o.err_code = STAT_BAD_SUM;
            cmd_o.restart  = 1'b1;
            state_d = ST_HEADER;
          end else begin
            cmd_o.reply_start = 1'b1;
            state_d = ST_REPLY;
          end
        end
      end
      ST_REPLY: begin
        if (!stat_i.out_hold) begin
          cmd_o.reply_step = 1'b1;
          if (stat_i.reply_end) begin
            cmd_o.restart = 1'b1;
            state_d = ST_HEADER;
          end
        end
      end
      default: state_d = ST_HEADER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  `FRR_ASSERT_NEXT(a_err_to_header, clk_i, rst_ni, cmd_o.err, state_q == ST_HEADER, "error item not followed by header phase")
  `FRR_ASSERT_NEXT(a_start_to_reply, clk_i, rst_ni, cmd_o.reply_start, state_q == ST_REPLY, "good checksum did not start reply")
  `FRR_ASSERT(a_no_load_on_hold, clk_i, rst_ni, !((cmd_o.err || cmd_o.reply_step) && stat_i.out_hold), "output loaded while held")

endmodule

`default_nettype wire

// File: src/frame_receive_and_reply_core.sv
// Top level of the frame receive and reply core.
//
// Takes link bytes one item per cycle while in_stall_o is low. A header whose
// first byte is not the sync byte yields one error item at its eighth byte; the
// checksum byte of a bad frame yields one error item, and that of a good frame
// starts a reply of 9 + length items, sent one per cycle while the output is not
// stalled, from a single output register while the header and payload buffers
// are walked; input stalls until the last reply item is loaded. The eighth header
// byte and the checksum byte are also stalled while a previous result still waits.
`default_nettype none

module frame_receive_and_reply_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      tx_byte_o,
  output logic [1:0]      status_o,
  output logic            last_o
);
  import frr_pkg::*;

  frr_cmd_t  cmd;
  frr_stat_t stat;

  frr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  frr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (rx_byte_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .tx_byte_o   (tx_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: sim/frame_receive_and_reply_core_tb.sv
// Self-checking testbench: link frames in, echoed replies and error items checked out.
`timescale 1ns / 100ps

module frame_receive_and_reply_core_tb;
  import frr_pkg::*;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         MAX_REPORTS = 10;

  typedef enum logic [1:0] {RX_HEADER, RX_PAYLOAD, RX_CHECKSUM} rx_phase_e;
  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_TOO_LONG, FR_NO_SYNC} frame_kind_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } reply_item_t;

  class frame_echo_scoreboard;
    logic [7:0]  cfg_cmd;
    logic [7:0]  ok_rsp;
    logic [7:0]  unknown_rsp;
    rx_phase_e   phase;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  pay [MAX_PAYLOAD];
    logic [31:0] count;
    logic [31:0] length;
    logic [7:0]  sum;
    reply_item_t pending [$];
    int          mismatches;
    int          checked;

    function new();
      cfg_cmd     = RST_CFG_CMD;
      ok_rsp      = RST_OK_RSP;
      unknown_rsp = RST_UNKNOWN_RSP;
      length      = 0;
      mismatches  = 0;
      checked     = 0;
      restart_frame();
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        REG_CFG_CMD:     cfg_cmd = data;
        REG_OK_RSP:      ok_rsp = data;
        REG_UNKNOWN_RSP: unknown_rsp = data;
        default: ;
      endcase
    endfunction

    function void restart_frame();
      phase = RX_HEADER;
      count = 0;
      sum   = 0;
    endfunction

    function void push(logic [7:0] b, logic [1:0] st, logic lst);
      pending.push_back('{b, st, lst});
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] rsp;
      logic [7:0] reply_sum;
      logic [7:0] hb;
      case (phase)
        RX_PAYLOAD: begin
          if (count < MAX_PAYLOAD) pay[count] = b;
          sum += b;
          count++;
          if (count == length) begin
            phase = RX_CHECKSUM;
            count = 0;
          end
        end
        RX_CHECKSUM: begin
          if (length > MAX_PAYLOAD) begin
            push(8'h00, STAT_TOO_LONG, 1'b1);
          end else if (sum != b) begin
            push(8'h00, STAT_BAD_SUM, 1'b1);
          end else begin
            rsp = (hdr[1] == cfg_cmd) ? ok_rsp : unknown_rsp;
            reply_sum = 0;
            for (int i = 0; i < HDR_LEN; i++) begin
              hb = (i == 3) ? rsp : hdr[i];
              reply_sum += hb;
              push(hb, STAT_OK, 1'b0);
            end
            for (int i = 0; i < length; i++) begin
              reply_sum += pay[i];
              push(pay[i], STAT_OK, 1'b0);
            end
            push(reply_sum, STAT_OK, 1'b1);
          end
          restart_frame();
        end
        default: begin
          phase = RX_HEADER;
          hdr[count[2:0]] = b;
          sum += b;
          count++;
          if (count >= HDR_LEN) begin
            if (hdr[0] != SYNC_BYTE) begin
              push(8'h00, STAT_BAD_SYNC, 1'b1);
              restart_frame();
            end else begin
              length = {hdr[7], hdr[6], hdr[5], hdr[4]};
              count  = 0;
              phase  = (length == 0) ? RX_CHECKSUM : RX_PAYLOAD;
            end
          end
        end
      endcase
    endfunction

    function void check_reply(logic [7:0] tx, logic [1:0] st, logic lst);
      reply_item_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: tx %h status %0d last %0d", tx, st, lst);
        return;
      end
      want = pending.pop_front();
      if (want.tx_byte !== tx || want.status !== st || want.last !== lst) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("item %0d: expected tx %h status %0d last %0d, got tx %h status %0d last %0d",
                   checked, want.tx_byte, want.status, want.last, tx, st, lst);
      end
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = REG_CFG_CMD;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i  = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic [1:0] status_o;
  logic       last_o;

  frame_echo_scoreboard sb;
  int unsigned stall_left = 0;
  bit          stall_on   = 1'b1;
  bit          gaps_on    = 1'b1;
  int unsigned bytes_sent = 0;
  int          frames_by_kind [4] = '{0, 0, 0, 0};

  frame_receive_and_reply_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_reply(tx_byte_o, status_o, last_o);
      stall_left <= stall_on ? $urandom_range(0, 7) : 0;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [7:0] cmd,
                            input int unsigned len, input int fill);
    logic [7:0] hdr [HDR_LEN];
    logic [7:0] b;
    logic [7:0] chk;
    chk    = 8'h00;
    hdr[0] = (kind == FR_NO_SYNC) ? 8'($urandom_range(0, 254)) : SYNC_BYTE;
    hdr[1] = cmd;
    hdr[2] = 8'($urandom);
    hdr[3] = 8'($urandom);
    {hdr[7], hdr[6], hdr[5], hdr[4]} = len;
    frames_by_kind[kind]++;
    for (int i = 0; i < HDR_LEN; i++) begin
      chk += hdr[i];
      send_byte(hdr[i]);
    end
    if (kind == FR_NO_SYNC) return;
    for (int unsigned i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      chk += b;
      send_byte(b);
    end
    if (kind == FR_BAD_SUM) chk += 8'($urandom_range(1, 255));
    else if (kind == FR_TOO_LONG && $urandom_range(0, 1)) chk = 8'($urandom);
    send_byte(chk);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (!sb.drained()) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] cmd, input logic [7:0] ok,
                              input logic [7:0] unknown, input logic [7:0] stray);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_CFG_CMD;
    cfg_data_i <= cmd;
    sb.write_reg(REG_CFG_CMD, cmd);
    @(negedge clk_i);
    cfg_idx_i  <= REG_OK_RSP;
    cfg_data_i <= ok;
    sb.write_reg(REG_OK_RSP, ok);
    @(negedge clk_i);
    cfg_idx_i  <= REG_UNKNOWN_RSP;
    cfg_data_i <= unknown;
    sb.write_reg(REG_UNKNOWN_RSP, unknown);
    @(negedge clk_i);
    // index past the last register must change nothing
    cfg_idx_i  <= REG_SPARE;
    cfg_data_i <= stray;
    sb.write_reg(REG_SPARE, stray);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_frames(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  cmd;
    frame_kind_e kind;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 60) ? FR_GOOD : (pick < 72) ? FR_BAD_SUM :
             (pick < 82) ? FR_TOO_LONG : FR_NO_SYNC;
      cmd  = $urandom_range(0, 1) ? sb.cfg_cmd : 8'($urandom);
      if (kind == FR_TOO_LONG) len = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 8);
      else if (kind == FR_NO_SYNC) len = $urandom;
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, MAX_PAYLOAD);
      else len = $urandom_range(0, 6);
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) drain_and_settle();
      send_frame(kind, cmd, len, -1);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_frame(FR_GOOD, RST_CFG_CMD, 0, -1);
    send_frame(FR_GOOD, 8'h00, 1, 8'hFF);
    send_frame(FR_NO_SYNC, RST_CFG_CMD, 0, -1);
    send_frame(FR_BAD_SUM, RST_CFG_CMD, 2, -1);
    send_frame(FR_GOOD, 8'hFF, MAX_PAYLOAD, 8'h00);
    send_frame(FR_GOOD, RST_CFG_CMD, MAX_PAYLOAD, 8'hFF);
    send_frame(FR_TOO_LONG, 8'h02, MAX_PAYLOAD + 1, -1);
    send_frame(FR_NO_SYNC, 8'hFF, 32'hFFFF_FFFF, -1);
    send_frame(FR_BAD_SUM, 8'h7E, 0, -1);

    drain_and_settle();
    program_regs(8'h00, 8'h00, 8'hFF, 8'h5A);
    send_frame(FR_GOOD, 8'h00, 0, -1);
    send_frame(FR_GOOD, 8'h01, 3, -1);
    random_frames(50);

    drain_and_settle();
    program_regs(8'hFF, 8'hFF, 8'h00, 8'hA5);
    send_frame(FR_GOOD, 8'hFF, 0, -1);
    random_frames(50);

    drain_and_settle();
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_frames(50);

    drain_and_settle();
    program_regs(RST_CFG_CMD, RST_OK_RSP, RST_UNKNOWN_RSP, 8'hFF);
    random_frames(50);

    in_valid_i <= 1'b0;
    while (!sb.drained()) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("sent %0d link bytes in %0d frames: %0d good, %0d bad checksum, %0d oversize, %0d bad sync",
             bytes_sent, frames_by_kind[FR_GOOD] + frames_by_kind[FR_BAD_SUM] +
             frames_by_kind[FR_TOO_LONG] + frames_by_kind[FR_NO_SYNC],
             frames_by_kind[FR_GOOD], frames_by_kind[FR_BAD_SUM],
             frames_by_kind[FR_TOO_LONG], frames_by_kind[FR_NO_SYNC]);
    $display("checked %0d output items over five register settings, %0d mismatches",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.drained()) begin
      $display("RESULT: OK");
    end else begin
      if (!sb.drained()) $display("%0d expected items never arrived", sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
